// ----- sv/sstf_pkg.sv -----
// ============================================================================
// sstf_pkg: shared constants for the SSTF disk scheduler
// Default sizes, port field widths and the movement sum limit.
// ============================================================================
package sstf_pkg;

    // Default sizes of the request store and of a stored track.
    localparam int MAX_REQUESTS_DEF = 32;
    localparam int TRACK_BITS_DEF   = 12;

    // Fixed widths of the port fields.
    localparam int PORT_TRACK_W = 12;
    localparam int SUM_W        = 17;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 48;

    // Total head movement saturates at the largest value the port can show.
    localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

endpackage

// ----- sv/sstf_disk_scheduler.sv -----
// ============================================================================
// sstf_disk_scheduler: shortest seek time first disk request scheduler
// Collects a batch of track requests, then serves them nearest first.
// ============================================================================
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tdata: track; tlast: last request
// m_axis    out  m_axis_tvalid/tready   tdata: served track, seek, total;
//                                       tlast: final result; tuser: overflow
// cfg       in   cfg_valid/cfg_ready    cfg_data: start position
//
// Loading accepts one request per cycle. Once the last request of a batch is
// taken, each served request takes a full scan: one read per entry of the
// request RAM through the single shared seek unit, then the registered read
// is drained, the end of the scan is detected and the result is emitted.
// Input is not accepted until the whole batch has been served.
// A result that waits in the output register stalls only the next emit; the
// next scan, and the loading of a new batch, go on meanwhile.
// Reset clears all control state at once, including the served marks; the
// request RAM needs no clearing, since only entries of the batch are read.

module sstf_disk_scheduler #(
    parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF,
    parameter int TRACK_BITS   = sstf_pkg::TRACK_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [11:0] track, [15:12] zero
    input  logic [sstf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [11:0] served_track, [23:12] seek_distance, [40:24] total_movement,
    // [47:41] zero
    output logic [sstf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    // [0] overflow
    output logic                             m_axis_tuser,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sstf_pkg::PORT_TRACK_W-1:0] cfg_data
);

    localparam int PW    = sstf_pkg::PORT_TRACK_W;
    localparam int SW    = sstf_pkg::SUM_W;
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    // The head may sit anywhere the start position reaches, so the seek
    // arithmetic is as wide as the wider of the stored and port tracks.
    localparam int HW    = (TRACK_BITS > PW) ? TRACK_BITS : PW;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [1:0]              state_reg, state_next;
    logic [PW-1:0]           start_reg, start_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        served_cnt_reg, served_cnt_next;
    logic [MAX_REQUESTS-1:0] served_reg, served_next;
    logic                    dropped_reg, dropped_next;
    logic [HW-1:0]           head_reg, head_next;
    logic [SW-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    pipe_valid_reg, pipe_valid_next;
    logic                    pipe_skip_reg, pipe_skip_next;
    logic [IDX_W-1:0]        pipe_idx_reg, pipe_idx_next;
    logic                    best_found_reg, best_found_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [HW-1:0]           best_dist_reg, best_dist_next;
    logic [HW-1:0]           best_track_reg, best_track_next;
    logic                    m_valid_reg, m_valid_next;
    logic [sstf_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                    m_last_reg, m_last_next;
    logic                    m_user_reg, m_user_next;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                    in_fire;
    logic                    issue;
    logic                    emit_fire;
    logic                    final_hit;
    logic [CNT_W-1:0]        served_cnt_inc;
    logic [TRACK_BITS+PW-1:0] in_ext;
    logic [TRACK_BITS-1:0]   store_track;
    logic [HW+PW-1:0]        start_ext;
    logic [HW+TRACK_BITS-1:0] entry_ext;
    logic [HW-1:0]           entry_hw;
    logic [TRACK_BITS-1:0]   ram_rdata;
    logic [HW-1:0]           seek_dist;
    logic                    seek_take;
    logic [HW+PW-1:0]        track_out_ext;
    logic [HW+PW-1:0]        dist_out_ext;
    logic [HW+SW:0]          dist_sum_ext;
    logic [SW:0]             sum_wide;
    logic [SW-1:0]           sum_sat;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign issue     = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);
    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);

    // The incoming track is cut or zero-extended to the stored width.
    assign in_ext      = {{TRACK_BITS{1'b0}}, s_axis_tdata[PW-1:0]};
    assign store_track = in_ext[TRACK_BITS-1:0];
    assign start_ext   = {{HW{1'b0}}, start_reg};
    assign entry_ext   = {{HW{1'b0}}, ram_rdata};
    assign entry_hw    = entry_ext[HW-1:0];

    assign served_cnt_inc = served_cnt_reg + CNT_W'(1);
    assign final_hit      = (served_cnt_inc == count_reg);

    assign track_out_ext = {{PW{1'b0}}, best_track_reg};
    assign dist_out_ext  = {{PW{1'b0}}, best_dist_reg};
    assign dist_sum_ext  = {{(SW + 1){1'b0}}, best_dist_reg};
    assign sum_wide      = {1'b0, sum_reg} + dist_sum_ext[SW:0];
    assign sum_sat       = (sum_wide > {1'b0, sstf_pkg::SUM_LIMIT})
                         ? sstf_pkg::SUM_LIMIT : sum_wide[SW-1:0];

    // ------------------------------------------------------------------
    // Request store
    // ------------------------------------------------------------------
    sstf_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .clk   (clk),
        .we    (in_fire && (count_reg < CNT_W'(MAX_REQUESTS))),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (store_track),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared seek unit: one stored entry per cycle against the best so far
    // ------------------------------------------------------------------
    sstf_seek_unit #(
        .W (HW)
    ) u_seek (
        .head       (head_reg),
        .entry      (entry_hw),
        .best_dist  (best_dist_reg),
        .best_found (best_found_reg),
        .distance   (seek_dist),
        .take       (seek_take)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        served_cnt_next = served_cnt_reg;
        served_next     = served_reg;
        dropped_next    = dropped_reg;
        head_next       = head_reg;
        sum_next        = sum_reg;
        rd_idx_next     = rd_idx_reg;
        pipe_valid_next = issue;
        pipe_skip_next  = 1'b0;
        pipe_idx_next   = rd_idx_reg[IDX_W-1:0];
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        best_track_next = best_track_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_user_next     = m_user_reg;

        if (cfg_valid)
        begin
            start_next = cfg_data;
        end

        if (issue)
        begin
            pipe_skip_next = served_reg[rd_idx_reg[IDX_W-1:0]];
            rd_idx_next    = rd_idx_reg + CNT_W'(1);
        end

        // Compare stage: the RAM data for pipe_idx_reg is here now.
        if (pipe_valid_reg && !pipe_skip_reg && seek_take)
        begin
            best_found_next = 1'b1;
            best_idx_next   = pipe_idx_reg;
            best_dist_next  = seek_dist;
            best_track_next = entry_hw;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (count_reg < CNT_W'(MAX_REQUESTS))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        // The head starts each batch from the register.
                        head_next       = start_ext[HW-1:0];
                        rd_idx_next     = '0;
                        best_found_next = 1'b0;
                        served_cnt_next = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!issue && !pipe_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(sstf_pkg::OUT_DATA_W - SW - 2 * PW){1'b0}},
                                    sum_sat,
                                    dist_out_ext[PW-1:0],
                                    track_out_ext[PW-1:0]};
                    m_last_next  = final_hit;
                    m_user_next  = dropped_reg;
                    if (final_hit)
                    begin
                        // End of the batch: back to an empty store.
                        served_next     = '0;
                        count_next      = '0;
                        served_cnt_next = '0;
                        sum_next        = '0;
                        dropped_next    = 1'b0;
                        head_next       = start_ext[HW-1:0];
                        state_next      = ST_LOAD;
                    end
                    else
                    begin
                        served_next[best_idx_reg] = 1'b1;
                        served_cnt_next = served_cnt_inc;
                        sum_next        = sum_sat;
                        head_next       = best_track_reg;
                        rd_idx_next     = '0;
                        best_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            start_reg      <= '0;
            count_reg      <= '0;
            served_cnt_reg <= '0;
            served_reg     <= '0;
            dropped_reg    <= 1'b0;
            head_reg       <= '0;
            sum_reg        <= '0;
            rd_idx_reg     <= '0;
            pipe_valid_reg <= 1'b0;
            best_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            count_reg      <= count_next;
            served_cnt_reg <= served_cnt_next;
            served_reg     <= served_next;
            dropped_reg    <= dropped_next;
            head_reg       <= head_next;
            sum_reg        <= sum_next;
            rd_idx_reg     <= rd_idx_next;
            pipe_valid_reg <= pipe_valid_next;
            best_found_reg <= best_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        pipe_skip_reg  <= pipe_skip_next;
        pipe_idx_reg   <= pipe_idx_next;
        best_idx_reg   <= best_idx_next;
        best_dist_reg  <= best_dist_next;
        best_track_reg <= best_track_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
        m_user_reg     <= m_user_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A batch being scheduled always holds at least one request.
    a_batch_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (count_reg != '0))
        else $error("scheduling with an empty request store");

    // Every emitted request was found by the scan and not served before.
    a_emit_unserved: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> (best_found_reg && !served_reg[best_idx_reg]))
        else $error("emitted request was not a fresh scan winner");

    // The final result of a batch leaves an empty store behind.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && final_hit) |=>
            (state_reg == ST_LOAD) && (count_reg == '0) && (served_reg == '0))
        else $error("batch state not cleared after the final result");

    // The number of served requests never reaches the batch size mid-batch.
    a_served_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (served_cnt_reg < count_reg))
        else $error("served count ran past the request count");

endmodule

// ----- sv/sstf_ram.sv -----
// ============================================================================
// sstf_ram: generic single write port, single read port RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module sstf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/sstf_seek_unit.sv -----
// ============================================================================
// sstf_seek_unit: shared distance and compare unit
// Forms the absolute distance from the head to one stored track and decides
// whether it beats the best candidate found so far in the current scan.
// ============================================================================
module sstf_seek_unit #(
    parameter int W = 12
) (
    input  logic [W-1:0] head,
    input  logic [W-1:0] entry,
    input  logic [W-1:0] best_dist,
    input  logic         best_found,
    output logic [W-1:0] distance,
    output logic         take
);

    always_comb
    begin
        distance = (head > entry) ? (head - entry) : (entry - head);
        // Strictly smaller only, so the earliest entry keeps a tie.
        take = !best_found || (distance < best_dist);
    end

endmodule

// ----- bench/sstf_disk_scheduler_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// sstf_disk_scheduler_test: self-checking bench for the SSTF disk scheduler
// Feeds batches of track requests, predicts the nearest-first service order
// with its own scheduler copy and checks every served request field by field.
// ============================================================================

module sstf_disk_scheduler_test;

    localparam int STORE_DEPTH  = sstf_pkg::MAX_REQUESTS_DEF;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_ITEMS  = 62;

    // One served request as it leaves the block.
    typedef struct packed {
        logic [11:0] served_track;
        logic [11:0] seek_distance;
        logic [16:0] total_movement;
        logic        final_result;
        logic        overflow;
    } seek_result_t;

    // Keeps the batch being loaded, works out the nearest-first order when the
    // last request arrives and holds the served requests still to come.
    class seek_schedule_tracker;
        logic [11:0]  start_track;
        logic [11:0]  batch_tracks[$];
        bit           batch_dropped;
        seek_result_t pending_seeks[$];
        int           errors;

        function new();
            start_track   = '0;
            batch_dropped = 0;
            errors        = 0;
        endfunction

        function void note_request(logic [11:0] track, logic last);
            bit           served[STORE_DEPTH];
            int           head;
            int           sum;
            int           best;
            int           best_dist;
            int           gap;
            int           k;
            int           i;
            seek_result_t r;
            if (batch_tracks.size() < STORE_DEPTH)
                batch_tracks.push_back(track);
            else
                batch_dropped = 1;
            if (!last)
                return;
            // The head starts from the register value at the moment the batch
            // closes, and the movement total starts from zero.
            head = start_track;
            sum  = 0;
            foreach (served[j])
                served[j] = 0;
            for (k = 0; k < batch_tracks.size(); k++)
            begin
                best      = -1;
                best_dist = 0;
                // A strict comparison keeps the earliest-loaded request on a tie.
                for (i = 0; i < batch_tracks.size(); i++)
                begin
                    if (!served[i])
                    begin
                        gap = (head > batch_tracks[i]) ? head - batch_tracks[i]
                                                       : batch_tracks[i] - head;
                        if (best < 0 || gap < best_dist)
                        begin
                            best      = i;
                            best_dist = gap;
                        end
                    end
                end
                served[best] = 1;
                head = batch_tracks[best];
                sum  = sum + best_dist;
                if (sum > sstf_pkg::SUM_LIMIT)
                    sum = sstf_pkg::SUM_LIMIT;
                r.served_track   = 12'(head);
                r.seek_distance  = 12'(best_dist);
                r.total_movement = 17'(sum);
                r.final_result   = (k == batch_tracks.size() - 1);
                r.overflow       = batch_dropped;
                pending_seeks.push_back(r);
            end
            batch_tracks.delete();
            batch_dropped = 0;
        endfunction

        function void check_served(seek_result_t got);
            seek_result_t want;
            if (pending_seeks.size() == 0)
            begin
                $error("unexpected served request: track %0d", got.served_track);
                errors++;
                return;
            end
            want = pending_seeks.pop_front();
            if (got.served_track !== want.served_track)
            begin
                $error("served_track: expected %0d, actual %0d",
                       want.served_track, got.served_track);
                errors++;
            end
            if (got.seek_distance !== want.seek_distance)
            begin
                $error("seek_distance: expected %0d, actual %0d",
                       want.seek_distance, got.seek_distance);
                errors++;
            end
            if (got.total_movement !== want.total_movement)
            begin
                $error("total_movement: expected %0d, actual %0d",
                       want.total_movement, got.total_movement);
                errors++;
            end
            if (got.final_result !== want.final_result)
            begin
                $error("final_result: expected %0d, actual %0d",
                       want.final_result, got.final_result);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
                errors++;
            end
        endfunction

        // Anything still waiting at the end never came out of the block.
        function int close_out();
            foreach (pending_seeks[j])
            begin
                $error("served request never seen: track %0d",
                       pending_seeks[j].served_track);
                errors++;
            end
            return errors;
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [sstf_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;
    logic                                s_axis_tlast = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [sstf_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                m_axis_tuser;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [sstf_pkg::PORT_TRACK_W-1:0]   cfg_data = '0;

    seek_schedule_tracker sched = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int quiet_cycles   = 0;

    sstf_disk_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls, or a counted hold-off when one is armed.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every handshake is observed here at the rising edge; the watchdog counts
    // cycles in which nothing at all is accepted.
    always @(posedge clk)
    begin
        seek_result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sched.start_track = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                sched.note_request(s_axis_tdata[11:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.served_track   = m_axis_tdata[11:0];
                got.seek_distance  = m_axis_tdata[23:12];
                got.total_movement = m_axis_tdata[40:24];
                got.final_result   = m_axis_tlast;
                got.overflow       = m_axis_tuser;
                sched.check_served(got);
            end
            if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [11:0] track, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, track};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stops offering requests and waits until every served request is back.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sched.pending_seeks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_start(input logic [11:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_batch(input logic [11:0] tracks[$]);
        foreach (tracks[j])
            send_request(tracks[j], j == tracks.size() - 1);
    endtask

    // Mostly uniform tracks, with the extremes and a tight cluster that makes
    // equal-distance ties likely.
    function automatic logic [11:0] pick_track();
        case ($urandom_range(5))
            0: pick_track = $urandom_range(1) ? 12'hFFF : 12'h000;
            1: pick_track = 12'd100 + 12'(10 * $urandom_range(4));
            default: pick_track = 12'($urandom);
        endcase
    endfunction

    // Batches are mostly short; now and then the store is filled exactly or
    // overrun so that extra requests are dropped.
    task automatic run_phase(input int idle_pct, input int stall_pct);
        int sent;
        int size;
        int j;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            case ($urandom_range(19))
                0: size = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1);
                1: size = STORE_DEPTH;
                default: size = $urandom_range(8, 1);
            endcase
            for (j = 0; j < size; j++)
                send_request(pick_track(), j == size - 1);
            sent += size;
        end
        wait_drained();
    endtask

    initial
    begin
        logic [11:0] burst[$];
        int j;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero-distance service, a tie between tracks on either side
        // of the head, and both ends of the disk.
        write_start(12'd2048);
        send_batch('{12'd2048, 12'd2000, 12'd2096, 12'd0, 12'd4095});
        wait_drained();
        // A single request seeking across the whole disk.
        write_start(12'd4095);
        send_batch('{12'd0});
        // Identical tracks are served in load order; only the first of them moves the head.
        send_batch('{12'd7, 12'd7, 12'd7});
        wait_drained();
        write_start(12'd0);
        send_batch('{12'hAAA, 12'h555, 12'hFFF, 12'h000, 12'h001});
        wait_drained();

        run_phase(0, 0);

        // The result side holds off while two batches are offered back to
        // back, so the block fills up and stops taking requests.
        hold_cycles = HOLD_CYCLES;
        for (j = 0; j < 8; j++)
            burst.push_back(pick_track());
        send_batch(burst);
        burst.delete();
        for (j = 0; j < 12; j++)
            burst.push_back(pick_track());
        send_batch(burst);
        wait_drained();

        write_start(12'($urandom));
        run_phase(77, 0);
        write_start(12'd4095);
        run_phase(0, 77);
        write_start(12'($urandom));
        run_phase(36, 36);

        if (sched.close_out() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
